### hw/rtl/rnnt_beta_lattice_cell_macros.svh
// ----------------------------------------------------------------------------
// rnnt_beta_lattice_cell_macros
// Assertion helpers used by the beta lattice cell checker.
// ----------------------------------------------------------------------------
`ifndef RNNT_BETA_LATTICE_CELL_MACROS_SVH
`define RNNT_BETA_LATTICE_CELL_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define RBLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rblc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rblc_pkg
// Constants, types and the softplus table builder for the beta lattice cell.
// ----------------------------------------------------------------------------
package rblc_pkg;

  localparam int MAX_T      = 1024;
  localparam int MAX_U      = 256;
  localparam int FRAC_BITS  = 16;
  localparam int SP_ENTRIES = 1024;

  localparam int SP_IDX_W = $clog2(SP_ENTRIES);
  localparam int SP_SHIFT = FRAC_BITS + 4 - SP_IDX_W;
  localparam int SP_W     = FRAC_BITS;

  localparam logic [31:0] NEG_INF = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0001;

  localparam longint unsigned Q30_ONE      = 64'd1073741824;
  localparam longint unsigned EXP_M1_Q30   = 64'd395007542;

  typedef enum logic [1:0] {
    KIND_OUTSIDE = 2'd0,
    KIND_FINAL   = 2'd1,
    KIND_RECUR   = 2'd2
  } cell_kind_e;

  typedef logic [SP_W-1:0] sp_rom_t [SP_ENTRIES];

  // restoring shift-subtract divide, elaboration only
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-x), x in Q4.30 below 16, result Q2.30
  function automatic longint unsigned exp_neg_q30(longint unsigned x);
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned term;
    longint          acc;
    longint unsigned y;
    whole = x >> 30;
    frac  = x & (Q30_ONE - 64'd1);
    term  = Q30_ONE;
    acc   = longint'(Q30_ONE);
    for (int k = 1; k <= 16; k++) begin
      term = (term * frac) >> 30;
      term = udiv64(term, longint'(k));
      if (k % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    y = longint'(acc);
    for (longint unsigned k = 0; k < whole; k++) begin
      y = (y * EXP_M1_Q30) >> 30;
    end
    return y;
  endfunction

  // ln(1+y), y in Q2.30 within [0,1], result Q2.30
  function automatic longint unsigned log1p_q30(longint unsigned y);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned pw;
    longint unsigned s;
    z  = udiv64(y << 30, (64'd2 << 30) + y);
    z2 = (z * z) >> 30;
    pw = z;
    s  = 0;
    for (int k = 1; k <= 41; k += 2) begin
      s  = s + udiv64(pw, longint'(k));
      pw = (pw * z2) >> 30;
    end
    return 2 * s;
  endfunction

  function automatic sp_rom_t build_sp_table();
    sp_rom_t         tbl;
    longint unsigned x;
    longint unsigned l;
    for (int i = 0; i < SP_ENTRIES; i++) begin
      x = (longint'(i) << 34) / SP_ENTRIES;
      l = log1p_q30(exp_neg_q30(x));
      l = (l + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      tbl[i] = l[SP_W-1:0];
    end
    return tbl;
  endfunction

endpackage

### hw/rtl/rnnt_beta_lattice_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnnt_beta_lattice_cell
// One cell of the RNN-T backward (beta) recursion, Q15.16 log domain.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one lattice cell per transfer: diagonal
//   index, label position, both lengths, the blank and label log-probs and
//   the two neighbor betas. Master stream m_axis returns one transfer per
//   input: beta of the cell in tdata and the cell kind in tuser.
//   Results pass through four registers: input register, path sums,
//   compare plus softplus ROM read, final add.
//   Throughput is one cell per cycle while the receiver does not stall;
//   the softplus ROM has one registered read port used once per cell.
//   Each stage advances when it is empty or the stage after it advances,
//   so bubbles collapse and input keeps flowing while a result waits.
//   A stalled receiver holds the output; s_axis_tready_o drops only when all
//   four stages are full.
//   Reset clears all stage valids; the ROM is constant and needs no fill.
// ----------------------------------------------------------------------------
module rnnt_beta_lattice_cell
  import rblc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // diag_index[10:0], label_pos[19:11], input_length[30:20],
  // label_length[39:31], logprob_blank[71:40], logprob_label[103:72],
  // beta_next_time[135:104], beta_next_label[167:136]
  input  logic [167:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // beta_out[31:0]
  output logic [31:0]  m_axis_tdata_o,
  // cell_kind[1:0]
  output logic [1:0]   m_axis_tuser_o
);

  localparam sp_rom_t SP_ROM = build_sp_table();

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    logic [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (a == NEG_INF || b == NEG_INF) r = NEG_INF;
    else if (s[32:31] == 2'b01) r = POS_MAX;
    else if (s[32:31] == 2'b10 || s[31:0] == NEG_INF) r = NEG_MIN;
    else r = s[31:0];
    return r;
  endfunction

  // stage valids and advance
  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d = !vd_q || m_axis_tready_i;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  assign s_axis_tready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= s_axis_tvalid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  // stage A: input register
  logic [10:0] diag_q, tlen_q;
  logic [8:0]  upos_q, ulen_q;
  logic [31:0] lp_blank_q, lp_label_q, b_time_q, b_label_q;

  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid_i) begin
      diag_q     <= s_axis_tdata_i[10:0];
      upos_q     <= s_axis_tdata_i[19:11];
      tlen_q     <= s_axis_tdata_i[30:20];
      ulen_q     <= s_axis_tdata_i[39:31];
      lp_blank_q <= s_axis_tdata_i[71:40];
      lp_label_q <= s_axis_tdata_i[103:72];
      b_time_q   <= s_axis_tdata_i[135:104];
      b_label_q  <= s_axis_tdata_i[167:136];
    end
  end

  // stage B: classify the cell, form both path sums
  logic [10:0] tlen_c, t_idx;
  logic [8:0]  ulen_c;
  logic        outside, last_t, last_u;
  logic [31:0] emit_d, noemit_d, emit_q, noemit_q;
  cell_kind_e  kind_b_d, kind_b_q;

  always_comb begin
    tlen_c  = (tlen_q > 11'(MAX_T)) ? 11'(MAX_T) : tlen_q;
    ulen_c  = (ulen_q > 9'(MAX_U)) ? 9'(MAX_U) : ulen_q;
    t_idx   = diag_q - {2'b00, upos_q};
    outside = (diag_q < {2'b00, upos_q}) || (t_idx >= tlen_c) || (upos_q > ulen_c);
    last_t  = (t_idx == tlen_c - 11'd1);
    last_u  = (upos_q == ulen_c);
    if (outside) begin
      kind_b_d = KIND_OUTSIDE;
      emit_d   = NEG_INF;
      noemit_d = NEG_INF;
    end else if (last_t && last_u) begin
      kind_b_d = KIND_FINAL;
      emit_d   = lp_blank_q;
      noemit_d = NEG_INF;
    end else begin
      kind_b_d = KIND_RECUR;
      emit_d   = last_u ? NEG_INF : sat_add(b_label_q, lp_label_q);
      noemit_d = last_t ? NEG_INF : sat_add(b_time_q, lp_blank_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      emit_q   <= emit_d;
      noemit_q <= noemit_d;
      kind_b_q <= kind_b_d;
    end
  end

  // stage C: larger path, difference, softplus ROM read
  logic [31:0]         hi_d, lo_d, diff, hi_q;
  logic [SP_IDX_W-1:0] sp_idx;
  logic                add_en_d, add_en_q;
  logic [SP_W-1:0]     sp_q;
  cell_kind_e          kind_c_q;

  always_comb begin
    if ($signed(emit_q) > $signed(noemit_q)) begin
      hi_d = emit_q;
      lo_d = noemit_q;
    end else begin
      hi_d = noemit_q;
      lo_d = emit_q;
    end
    diff     = hi_d - lo_d;
    sp_idx   = diff[SP_SHIFT +: SP_IDX_W];
    add_en_d = (emit_q != NEG_INF) && (noemit_q != NEG_INF) &&
               ((diff >> (SP_SHIFT + SP_IDX_W)) == 32'd0);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      hi_q     <= hi_d;
      add_en_q <= add_en_d;
      kind_c_q <= kind_b_q;
      sp_q     <= SP_ROM[sp_idx];
    end
  end

  // stage D: add softplus, saturate high
  logic [32:0] sum_w;
  logic [31:0] beta_d, beta_q;
  cell_kind_e  kind_d_q;

  always_comb begin
    sum_w  = {hi_q[31], hi_q} + (add_en_q ? 33'(sp_q) : 33'd0);
    beta_d = (sum_w[32:31] == 2'b01) ? POS_MAX : sum_w[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && vc_q) begin
      beta_q   <= beta_d;
      kind_d_q <= kind_c_q;
    end
  end

  assign m_axis_tvalid_o = vd_q;
  assign m_axis_tdata_o  = beta_q;
  assign m_axis_tuser_o  = kind_d_q;

endmodule

### hw/rtl/rblc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rblc_checker
// Port-level checks for the beta lattice cell, bound to the top level.
// ----------------------------------------------------------------------------
`include "rnnt_beta_lattice_cell_macros.svh"

module rblc_checker
  import rblc_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [167:0] s_axis_tdata_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [31:0]  m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);

  logic unused_in;
  assign unused_in = s_axis_tvalid_i ^ (^s_axis_tdata_i);

  `RBLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "output changed while stalled")
  `RBLC_ASSERT_IMP(a_outside_neg_inf, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o == KIND_OUTSIDE), m_axis_tdata_o == NEG_INF, "outside cell must give minus infinity")
  `RBLC_ASSERT_IMP(a_full_only_on_stall, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i, "input blocked without output stall")

endmodule

bind rnnt_beta_lattice_cell rblc_checker u_rblc_checker (.*);

### tb/rnnt_beta_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnnt_beta_checker
// Watches both streams of the beta lattice cell and checks each result.
// Every input transfer is turned into an expected beta and cell kind by a
// local Q15.16 model of the backward recursion. That model has its own
// softplus table, built at time zero. Output transfers are compared in order
// against the oldest expected cell.
// ----------------------------------------------------------------------------
module rnnt_beta_checker
  import rblc_pkg::cell_kind_e;
  import rblc_pkg::KIND_OUTSIDE;
  import rblc_pkg::KIND_FINAL;
  import rblc_pkg::KIND_RECUR;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [167:0] s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [31:0]  m_tdata_i,
  input  logic [1:0]   m_tuser_i,
  output int           mismatch_cnt_o,
  output int           pending_o
);

  localparam int      LEN_T_MAX  = 1024;
  localparam int      LEN_U_MAX  = 256;
  localparam int      Q_FRAC     = 16;
  localparam int      SOFTPLUS_N = 1024;
  localparam longint  LOG_NEG_INF = -64'sd2147483648;
  localparam longint  LOG_POS_MAX = 64'sd2147483647;
  localparam longint unsigned Q30_UNIT = 64'd1073741824;
  localparam longint unsigned Q30_EXP_M1 = 64'd395007542;

  typedef struct packed {
    logic [31:0] beta;
    cell_kind_e  kind;
  } beta_expect_t;

  longint       softplus_q [SOFTPLUS_N];
  beta_expect_t beta_expect_q [$];
  beta_expect_t head;

  initial mismatch_cnt_o = 0;
  initial pending_o = 0;

  // exp(-x), Q4.30 in, Q2.30 out
  function automatic longint unsigned q30_exp_neg(longint unsigned x);
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned term;
    longint unsigned y;
    longint          acc;
    whole = x >> 30;
    frac  = x & (Q30_UNIT - 64'd1);
    term  = Q30_UNIT;
    acc   = Q30_UNIT;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * frac) >> 30) / k;
      if (k % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    if (acc < 0) acc = 0;
    y = acc;
    for (longint unsigned k = 0; k < whole; k++) y = (y * Q30_EXP_M1) >> 30;
    return y;
  endfunction

  // ln(1+y) via the atanh series, Q2.30 in and out
  function automatic longint unsigned q30_ln1p(longint unsigned y);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned pw;
    longint unsigned s;
    z  = (y << 30) / ((64'd2 << 30) + y);
    z2 = (z * z) >> 30;
    pw = z;
    s  = 0;
    for (int k = 1; k <= 41; k += 2) begin
      s  = s + pw / k;
      pw = (pw * z2) >> 30;
    end
    return 2 * s;
  endfunction

  initial begin
    longint unsigned xi;
    longint unsigned l;
    for (int i = 0; i < SOFTPLUS_N; i++) begin
      xi = i;
      l  = q30_ln1p(q30_exp_neg((xi << 34) / SOFTPLUS_N));
      softplus_q[i] = (l + (64'd1 << (29 - Q_FRAC))) >> (30 - Q_FRAC);
    end
  end

  function automatic longint path_sum(longint a, longint b);
    longint s;
    if (a == LOG_NEG_INF || b == LOG_NEG_INF) return LOG_NEG_INF;
    s = a + b;
    if (s > LOG_POS_MAX) return LOG_POS_MAX;
    if (s < LOG_NEG_INF + 1) return LOG_NEG_INF + 1;
    return s;
  endfunction

  function automatic longint log_add(longint a, longint b);
    longint          hi;
    longint          lo;
    longint          r;
    longint unsigned idx;
    if (a == LOG_NEG_INF) return b;
    if (b == LOG_NEG_INF) return a;
    hi  = (a > b) ? a : b;
    lo  = (a > b) ? b : a;
    idx = ((hi - lo) * SOFTPLUS_N) >> (Q_FRAC + 4);
    r   = hi + ((idx < SOFTPLUS_N) ? softplus_q[idx] : 0);
    if (r > LOG_POS_MAX) r = LOG_POS_MAX;
    return r;
  endfunction

  function automatic beta_expect_t predict_beta(input logic [167:0] d);
    longint       n;
    longint       u;
    longint       t;
    longint       tl;
    longint       ul;
    longint       blank;
    longint       label;
    longint       no_emit;
    longint       emit;
    longint       res;
    beta_expect_t e;
    n     = longint'(d[10:0]);
    u     = longint'(d[19:11]);
    tl    = longint'(d[30:20]);
    ul    = longint'(d[39:31]);
    blank = longint'($signed(d[71:40]));
    label = longint'($signed(d[103:72]));
    t     = n - u;
    if (tl > LEN_T_MAX) tl = LEN_T_MAX;
    if (ul > LEN_U_MAX) ul = LEN_U_MAX;
    if (t < 0 || t >= tl || u > ul) begin
      res    = LOG_NEG_INF;
      e.kind = KIND_OUTSIDE;
    end else if (t == tl - 1 && u == ul) begin
      res    = blank;
      e.kind = KIND_FINAL;
    end else begin
      no_emit = (t == tl - 1) ? LOG_NEG_INF
                              : path_sum(longint'($signed(d[135:104])), blank);
      emit    = (u == ul) ? LOG_NEG_INF
                          : path_sum(longint'($signed(d[167:136])), label);
      res     = log_add(emit, no_emit);
      e.kind  = KIND_RECUR;
    end
    e.beta = res[31:0];
    return e;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
    mismatch_cnt_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) beta_expect_q.push_back(predict_beta(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (beta_expect_q.size() == 0) begin
          flag_mismatch("unexpected transfer", m_tdata_i, 32'h0);
        end else begin
          head = beta_expect_q.pop_front();
          if (m_tdata_i !== head.beta) flag_mismatch("beta", m_tdata_i, head.beta);
          if (m_tuser_i !== head.kind)
            flag_mismatch("kind", 32'(m_tuser_i), 32'(head.kind));
        end
      end
      pending_o <= beta_expect_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RNN-T beta lattice cell.
// A short directed set covers the lattice border, the final cell, clamped
// lengths, minus infinity and saturation. Random cells follow, mostly
// in-lattice with realistic log values plus raw noise. Sender and receiver
// idling is varied over three phases. Checking lives in rnnt_beta_checker.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [31:0] LQ_NEG_INF = 32'h8000_0000;
  localparam logic [31:0] LQ_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] LQ_MIN     = 32'h8000_0001;
  localparam int          CELLS_PER_PHASE = 545;
  localparam int          STALL_LIMIT     = 2000;
  localparam int          DRAIN_CYCLES    = 16;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [167:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [31:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  int mismatch_cnt;
  int pending;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  rnnt_beta_lattice_cell DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  rnnt_beta_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid_i),
    .s_tready_i     (s_axis_tready_o),
    .s_tdata_i      (s_axis_tdata_i),
    .m_tvalid_i     (m_axis_tvalid_o),
    .m_tready_i     (m_axis_tready_i),
    .m_tdata_i      (m_axis_tdata_o),
    .m_tuser_i      (m_axis_tuser_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_cell(input logic [10:0] n, input logic [8:0] u,
                           input logic [10:0] tl, input logic [8:0] ul,
                           input logic [31:0] blank, input logic [31:0] label,
                           input logic [31:0] btime, input logic [31:0] blabel);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {blabel, btime, label, blank, ul, tl, u, n};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic logic [31:0] rand_logval();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return LQ_NEG_INF;
    if (r < 12) return r[0] ? LQ_MAX : LQ_MIN;
    if (r < 25) return $urandom;
    return -$urandom_range(0, 40 << 16);
  endfunction

  task automatic send_random_cell();
    int          tc;
    int          uc;
    int          tt;
    int          uu;
    logic [10:0] n;
    logic [10:0] tl;
    logic [8:0]  u;
    logic [8:0]  ul;
    logic [31:0] blank;
    logic [31:0] label;
    logic [31:0] btime;
    logic [31:0] blabel;
    if ($urandom_range(99) < 12) begin
      n = 11'($urandom); u = 9'($urandom); tl = 11'($urandom); ul = 9'($urandom);
      blank = $urandom; label = $urandom; btime = $urandom; blabel = $urandom;
    end else begin
      case ($urandom_range(9))
        0:       tl = 11'($urandom_range(1025, 2047));
        1:       tl = 11'($urandom_range(64, 1024));
        default: tl = 11'($urandom_range(1, 48));
      endcase
      case ($urandom_range(9))
        0:       ul = 9'($urandom_range(257, 511));
        1:       ul = 9'($urandom_range(33, 256));
        default: ul = 9'($urandom_range(0, 16));
      endcase
      tc = (tl > 1024) ? 1024 : int'(tl);
      uc = (ul > 256) ? 256 : int'(ul);
      tt = $urandom_range(0, tc - 1);
      uu = $urandom_range(0, uc);
      case ($urandom_range(7))
        0: tt = tc - 1;
        1: uu = uc;
        2: begin
          tt = tc - 1;
          uu = uc;
        end
        3: begin
          if ($urandom_range(1)) uu = uc + 1;
          else tt = tc;
        end
        default: ;
      endcase
      n = 11'(tt + uu);
      u = 9'(uu);
      blank = rand_logval();
      label = rand_logval();
      btime = rand_logval();
      blabel = rand_logval();
      // pull the two paths close so the softplus table gets exercised
      if ($urandom_range(1))
        blabel = btime + blank - label + ($urandom_range(0, 34 << 16) - (17 << 16));
    end
    send_cell(n, u, tl, ul, blank, label, btime, blabel);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni        <= 1'b1;
    src_idle_pct  <= 20;
    sink_idle_pct <= 52;
    @(posedge clk_i);

    // lattice border, lengths, final cell
    send_cell(0, 0, 1, 0, LQ_MAX, 32'h0, 32'h0, 32'h0);
    send_cell(1279, 256, 2047, 511, LQ_NEG_INF, 32'h0, 32'h0, 32'h0);
    send_cell(0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cell(3, 5, 10, 10, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0);
    send_cell(12, 2, 10, 5, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0);
    send_cell(6, 6, 10, 5, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0);
    send_cell(2047, 511, 2047, 511, '1, '1, '1, '1);
    send_cell(1024, 256, 1024, 256, 32'hFFFE_0000, 32'hFFFD_0000, 32'hFFF0_0000,
              32'hFFF8_0000);
    send_cell(0, 0, 1, 1, '1, '1, '1, '1);
    // last time frame, last label
    send_cell(5, 1, 5, 3, 32'hFFFF_0000, 32'hFFFE_8000, 32'hFFFC_0000, 32'hFFFA_0000);
    send_cell(4, 3, 5, 3, 32'hFFFF_0000, 32'hFFFE_8000, 32'hFFFC_0000, 32'hFFFA_0000);
    send_cell(4, 3, 5, 3, LQ_NEG_INF, 32'h0, 32'h0, 32'h0);
    // recursion: equal paths, minus infinity, saturation, far apart paths
    send_cell(3, 1, 8, 4, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    send_cell(3, 1, 8, 4, 32'hFFFF_0000, 32'hFFFF_0000, LQ_NEG_INF, 32'hFFFE_0000);
    send_cell(3, 1, 8, 4, 32'hFFFF_0000, LQ_NEG_INF, 32'hFFFE_0000, 32'hFFFE_0000);
    send_cell(3, 1, 8, 4, LQ_NEG_INF, LQ_NEG_INF, 32'h0, 32'h0);
    send_cell(3, 1, 8, 4, LQ_MAX, 32'h1, LQ_MAX, LQ_MAX);
    send_cell(3, 1, 8, 4, 32'hC000_0000, 32'hC000_0000, LQ_MIN, LQ_MIN);
    send_cell(3, 1, 8, 4, 32'h0, 32'h0, 32'h0, 32'hFFEC_0000);

    repeat (CELLS_PER_PHASE) send_random_cell();
    src_idle_pct  <= 52;
    sink_idle_pct <= 20;
    repeat (CELLS_PER_PHASE) send_random_cell();
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    repeat (CELLS_PER_PHASE) send_random_cell();
    s_axis_tvalid_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rblc_pkg.sv
hw/rtl/rnnt_beta_lattice_cell.sv
hw/rtl/rblc_checker.sv
tb/rnnt_beta_checker.sv
tb/tb.sv
